### src/tim_pkg.sv
// Package for the tracking-id map with aging.
// Holds field widths, operation and status codes, and the control structs
// shared by the controller and the datapath. Depends on nothing.
package tim_pkg;

  // Table size default
  localparam int TABLE_ENTRIES_DEF = 64;

  // Field widths
  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int ID_W     = 64;
  localparam int LIFE_W   = 10;
  localparam int STATUS_W = 3;
  localparam int EVICT_W  = 7;

  // Lifetime register reset value
  localparam logic [LIFE_W-1:0] LIFE_RESET = LIFE_W'(30);

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TICK_DONE = 3'd5;

  // Saturation limit of the eviction count
  localparam logic [EVICT_W-1:0] EVICT_MAX = '1;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;   // latch a new request
    logic scan;     // walk the table, one entry per cycle
    logic finish;   // close out the request after the walk
    logic publish;  // move the result into the output register
  } tim_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic early_done; // lookup hit or duplicate key found
    logic scan_end;   // last entry compared this cycle
    logic out_free;   // output register can take a result
  } tim_sts_t;

endpackage

### src/tim_in_if.sv
// Request channel of the tracking-id map: valid/ready plus request fields.
// Depends on tim_pkg for field widths.
interface tim_in_if;
  import tim_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [KEY_W-1:0]  track_key;
  logic [ID_W-1:0]          object_id_high;
  logic [ID_W-1:0]          object_id_low;

  modport source (output valid, operation, track_key, object_id_high, object_id_low,
                  input ready);
  modport sink   (input valid, operation, track_key, object_id_high, object_id_low,
                  output ready);
endinterface

### src/tim_out_if.sv
// Result channel of the tracking-id map: valid/ready plus result fields.
// Depends on tim_pkg for field widths.
interface tim_out_if;
  import tim_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [ID_W-1:0]       found_id_high;
  logic [ID_W-1:0]       found_id_low;
  logic [EVICT_W-1:0]    evicted_count;

  modport source (output valid, status, found_id_high, found_id_low, evicted_count,
                  input ready);
  modport sink   (input valid, status, found_id_high, found_id_low, evicted_count,
                  output ready);
endinterface

### src/tracking_id_map_with_aging_top.sv
// Tracking-id map with aging, top level. A table of TABLE_ENTRIES entries
// maps 32-bit tracking ids to 128-bit object ids; requests are lookup,
// insert and frame tick, each answered by exactly one result. The table
// lives in one RAM word per entry (key, id, lifetime) with valid and seen
// flags in flip-flops, and every request walks it one entry per cycle
// through the RAM read port. A lookup that hits, or an insert that finds
// its key already present, ends the walk at the matching entry; a miss,
// any other insert and a frame tick walk the whole table. The next request
// is taken while a finished result still waits in the output register. The
// user must write the lifetime register through cfg_wr_en/cfg_wr_data only
// while no request is in progress; the block itself does not enforce it.
// Depends on tim_pkg, tim_in_if, tim_out_if, tim_ram, tim_ctrl, tim_dp.
module tracking_id_map_with_aging_top #(
  parameter int TABLE_ENTRIES = tim_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tim_in_if.sink                     in_req,
  tim_out_if.source                  out_rsp,
  input  logic                       cfg_wr_en,
  input  logic [tim_pkg::LIFE_W-1:0] cfg_wr_data
);
  import tim_pkg::*;

  tim_cmd_t cmd;
  tim_sts_t sts;

  // Sequencer
  tim_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_req.valid),
    .in_ready(in_req.ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Table and result path
  tim_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_req.operation),
    .in_track_key     (in_req.track_key),
    .in_object_id_high(in_req.object_id_high),
    .in_object_id_low (in_req.object_id_low),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_ready        (out_rsp.ready),
    .out_valid        (out_rsp.valid),
    .out_status       (out_rsp.status),
    .out_found_id_high(out_rsp.found_id_high),
    .out_found_id_low (out_rsp.found_id_low),
    .out_evicted_count(out_rsp.evicted_count)
  );

endmodule

### src/tim_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/tim_ctrl.sv
// Controller of the tracking-id map: one-hot state machine that sequences
// accept, table walk, close-out and result hand-off. Depends on tim_pkg.
module tim_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tim_pkg::tim_sts_t sts,
  output tim_pkg::tim_cmd_t cmd
);
  import tim_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FINISH = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.early_done) begin
          state_nxt = S_DONE;
        end else if (sts.scan_end) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        cmd.publish = sts.out_free;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/tim_dp.sv
// Datapath of the tracking-id map: request latch, table RAM, valid/seen
// flags, walk counter, result and output registers. Depends on tim_pkg, tim_ram.
module tim_dp #(
  parameter int TABLE_ENTRIES = tim_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tim_pkg::tim_cmd_t               cmd,
  output tim_pkg::tim_sts_t               sts,
  // request fields
  input  logic [tim_pkg::OP_W-1:0]        in_operation,
  input  logic signed [tim_pkg::KEY_W-1:0] in_track_key,
  input  logic [tim_pkg::ID_W-1:0]        in_object_id_high,
  input  logic [tim_pkg::ID_W-1:0]        in_object_id_low,
  // lifetime register write
  input  logic                            cfg_wr_en,
  input  logic [tim_pkg::LIFE_W-1:0]      cfg_wr_data,
  // result channel
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [tim_pkg::STATUS_W-1:0]    out_status,
  output logic [tim_pkg::ID_W-1:0]        out_found_id_high,
  output logic [tim_pkg::ID_W-1:0]        out_found_id_low,
  output logic [tim_pkg::EVICT_W-1:0]     out_evicted_count
);
  import tim_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int RAM_W = KEY_W + 2 * ID_W + LIFE_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);

  // Lifetime register
  logic [LIFE_W-1:0] lifetime_r;

  // Latched request
  logic [OP_W-1:0]  op_r;
  logic [KEY_W-1:0] key_r;
  logic [ID_W-1:0]  idh_r, idl_r;

  // Walk state
  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic             chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic             free_found_r, free_found_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [EVICT_W-1:0] evict_r, evict_nxt;

  // Per-entry flags
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [TABLE_ENTRIES-1:0] seen_r, seen_nxt;

  // Pending result
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [ID_W-1:0]     res_idh_r, res_idh_nxt;
  logic [ID_W-1:0]     res_idl_r, res_idl_nxt;
  logic [EVICT_W-1:0]  res_evict_r, res_evict_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [ID_W-1:0]     out_idh_r, out_idl_r;
  logic [EVICT_W-1:0]  out_evict_r;

  // Table RAM
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr;
  logic [RAM_W-1:0]  ram_wdata, ram_q;

  logic [KEY_W-1:0]  q_key;
  logic [ID_W-1:0]   q_idh, q_idl;
  logic [LIFE_W-1:0] q_life;
  logic              chk, ent_valid, ent_seen, match;

  tim_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_ENTRIES),
    .ADDR_W(IDX_W)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(rd_cnt_r[IDX_W-1:0]),
    .rdata(ram_q)
  );

  // Split the table word: key, id high, id low, life
  assign q_key  = ram_q[RAM_W-1 -: KEY_W];
  assign q_idh  = ram_q[RAM_W-KEY_W-1 -: ID_W];
  assign q_idl  = ram_q[RAM_W-KEY_W-ID_W-1 -: ID_W];
  assign q_life = ram_q[LIFE_W-1:0];

  // Compare stage: entry chk_idx_r has its RAM word this cycle
  assign chk       = cmd.scan && chk_v_r;
  assign ent_valid = valid_r[chk_idx_r];
  assign ent_seen  = seen_r[chk_idx_r];
  assign match     = chk && ent_valid && (q_key == key_r);

  assign sts.early_done = match && ((op_r == OP_LOOKUP) || (op_r == OP_INSERT));
  assign sts.scan_end   = chk && (chk_idx_r == LAST_IDX);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign ram_re = cmd.scan && (rd_cnt_r < CNT_END);

  // Walk, table update and result formation
  always_comb begin
    rd_cnt_nxt     = rd_cnt_r;
    chk_v_nxt      = chk_v_r;
    chk_idx_nxt    = chk_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    evict_nxt      = evict_r;
    valid_nxt      = valid_r;
    seen_nxt       = seen_r;
    res_status_nxt = res_status_r;
    res_idh_nxt    = res_idh_r;
    res_idl_nxt    = res_idl_r;
    res_evict_nxt  = res_evict_r;
    ram_we         = 1'b0;
    ram_waddr      = chk_idx_r;
    ram_wdata      = {ram_q[RAM_W-1:LIFE_W], lifetime_r};

    // New request: restart the walk, clear the result
    if (cmd.accept) begin
      rd_cnt_nxt     = '0;
      chk_v_nxt      = 1'b0;
      free_found_nxt = 1'b0;
      evict_nxt      = '0;
      res_status_nxt = ST_MISS;
      res_idh_nxt    = '0;
      res_idl_nxt    = '0;
      res_evict_nxt  = '0;
    end

    // Issue the next read
    if (cmd.scan) begin
      if (rd_cnt_r < CNT_END) begin
        chk_v_nxt   = 1'b1;
        chk_idx_nxt = rd_cnt_r[IDX_W-1:0];
        rd_cnt_nxt  = rd_cnt_r + CNT_W'(1);
      end else begin
        chk_v_nxt = 1'b0;
      end
    end

    // Act on the entry being compared
    if (chk) begin
      case (op_r)
        OP_LOOKUP: begin
          if (match) begin
            seen_nxt[chk_idx_r] = 1'b1;
            res_status_nxt      = ST_HIT;
            res_idh_nxt         = q_idh;
            res_idl_nxt         = q_idl;
          end
        end
        OP_INSERT: begin
          if (match) begin
            res_status_nxt = ST_DUPLICATE;
          end
          if (!ent_valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = chk_idx_r;
          end
        end
        OP_TICK: begin
          if (ent_valid) begin
            if (ent_seen) begin
              ram_we    = 1'b1;
              ram_wdata = {ram_q[RAM_W-1:LIFE_W], lifetime_r};
            end else if (q_life == '0) begin
              valid_nxt[chk_idx_r] = 1'b0;
              if (evict_r != EVICT_MAX) begin
                evict_nxt = evict_r + EVICT_W'(1);
              end
            end else begin
              ram_we    = 1'b1;
              ram_wdata = {ram_q[RAM_W-1:LIFE_W], q_life - LIFE_W'(1)};
            end
          end
          seen_nxt[chk_idx_r] = 1'b0;
        end
        default: begin
        end
      endcase
    end

    // Close out after the full walk
    if (cmd.finish) begin
      case (op_r)
        OP_LOOKUP: begin
          res_status_nxt = ST_MISS;
        end
        OP_INSERT: begin
          if (free_found_r) begin
            ram_we                = 1'b1;
            ram_waddr             = free_idx_r;
            ram_wdata             = {key_r, idh_r, idl_r, lifetime_r};
            valid_nxt[free_idx_r] = 1'b1;
            seen_nxt[free_idx_r]  = 1'b0;
            res_status_nxt        = ST_INSERTED;
          end else begin
            res_status_nxt = ST_FULL;
          end
        end
        OP_TICK: begin
          res_status_nxt = ST_TICK_DONE;
          res_evict_nxt  = evict_r;
        end
        default: begin
          res_status_nxt = ST_MISS;
        end
      endcase
    end
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r   <= LIFE_RESET;
      valid_r      <= '0;
      seen_r       <= '0;
      chk_v_r      <= 1'b0;
      rd_cnt_r     <= '0;
      free_found_r <= 1'b0;
      evict_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lifetime_r <= cfg_wr_data;
      end
      valid_r      <= valid_nxt;
      seen_r       <= seen_nxt;
      chk_v_r      <= chk_v_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      free_found_r <= free_found_nxt;
      evict_r      <= evict_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_operation;
      key_r <= in_track_key;
      idh_r <= in_object_id_high;
      idl_r <= in_object_id_low;
    end
    chk_idx_r    <= chk_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    res_status_r <= res_status_nxt;
    res_idh_r    <= res_idh_nxt;
    res_idl_r    <= res_idl_nxt;
    res_evict_r  <= res_evict_nxt;
    if (cmd.publish) begin
      out_status_r <= res_status_r;
      out_idh_r    <= res_idh_r;
      out_idl_r    <= res_idl_r;
      out_evict_r  <= res_evict_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found_id_high = out_idh_r;
  assign out_found_id_low  = out_idl_r;
  assign out_evicted_count = out_evict_r;

endmodule
